// ===== hw/rtl/ppmrc_pkg.sv =====
// Shared types, register indexes and constants of the PPM radio-control channel decoder.
package ppmrc_pkg;

    localparam int NUM_CHANNELS = 8;

    localparam int TIME_W     = 32;
    localparam int WIDTH_W    = 12;
    localparam int SET_W      = 13;
    localparam int GAP_W      = 16;
    localparam int DEADBAND_W = 10;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 56;

    localparam logic [CFG_ADDR_W-1:0] CFG_SYNC_GAP      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_WIDTH     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_WIDTH     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ARM_THRESHOLD = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_YAW_DEADBAND  = 3'd4;

    localparam logic [GAP_W-1:0]      RST_SYNC_GAP      = 16'd3000;
    localparam logic [WIDTH_W-1:0]    RST_MIN_WIDTH     = 12'd800;
    localparam logic [WIDTH_W-1:0]    RST_MAX_WIDTH     = 12'd2200;
    localparam logic [WIDTH_W-1:0]    RST_ARM_THRESHOLD = 12'd1750;
    localparam logic [DEADBAND_W-1:0] RST_YAW_DEADBAND  = 10'd15;

    localparam int CH_ROLL     = 0;
    localparam int CH_PITCH    = 1;
    localparam int CH_THROTTLE = 2;
    localparam int CH_YAW      = 3;
    localparam int CH_ARM      = 4;

    localparam logic signed [SET_W-1:0] MID_WIDTH = 13'sd1500;
    localparam logic signed [SET_W-1:0] LOW_WIDTH = 13'sd1000;

    typedef struct packed {
        logic [GAP_W-1:0]      sync_gap;
        logic [WIDTH_W-1:0]    min_width;
        logic [WIDTH_W-1:0]    max_width;
        logic [WIDTH_W-1:0]    arm_threshold;
        logic [DEADBAND_W-1:0] yaw_deadband;
    } t_cfg;

    typedef struct packed {
        logic [WIDTH_W-1:0] roll_w;
        logic [WIDTH_W-1:0] pitch_w;
        logic [WIDTH_W-1:0] throttle_w;
        logic [WIDTH_W-1:0] yaw_w;
        logic [WIDTH_W-1:0] arm_w;
        logic               sync;
    } t_snap;

endpackage

// ===== hw/rtl/ppmrc_frame.sv =====
// Frame tracker: edge interval, sync detection, channel index and channel width store.
module ppmrc_frame #(
    parameter int NUM_CHANNELS = ppmrc_pkg::NUM_CHANNELS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_step,
    input  logic [ppmrc_pkg::TIME_W-1:0]         i_edge_time,
    input  ppmrc_pkg::t_cfg                      i_cfg,
    output ppmrc_pkg::t_snap                     o_snap
);

    localparam int IDX_W  = $clog2(NUM_CHANNELS + 1);
    localparam int ADDR_W = $clog2(NUM_CHANNELS);
    localparam int TW     = ppmrc_pkg::TIME_W;
    localparam int WW     = ppmrc_pkg::WIDTH_W;

    logic [TW-1:0]    r_last_time;
    logic [IDX_W-1:0] r_index;
    logic [WW-1:0]    r_width [NUM_CHANNELS];

    logic [IDX_W-1:0] n_index;
    logic [WW-1:0]    n_width [NUM_CHANNELS];
    logic [TW-1:0]    dt;
    logic             is_sync;
    logic             in_window;

    always_comb begin
        dt        = i_edge_time - r_last_time;
        is_sync   = dt > TW'(i_cfg.sync_gap);
        in_window = (dt > TW'(i_cfg.min_width)) && (dt < TW'(i_cfg.max_width));
        n_index   = r_index;
        n_width   = r_width;
        if (is_sync) begin
            n_index = '0;
        end else if (r_index < IDX_W'(NUM_CHANNELS)) begin
            if (in_window) begin
                n_width[r_index[ADDR_W-1:0]] = dt[WW-1:0];
            end
            n_index = r_index + IDX_W'(1);
        end
        o_snap.roll_w     = n_width[ppmrc_pkg::CH_ROLL];
        o_snap.pitch_w    = n_width[ppmrc_pkg::CH_PITCH];
        o_snap.throttle_w = n_width[ppmrc_pkg::CH_THROTTLE];
        o_snap.yaw_w      = n_width[ppmrc_pkg::CH_YAW];
        o_snap.arm_w      = n_width[ppmrc_pkg::CH_ARM];
        o_snap.sync       = is_sync;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
            r_index     <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_width[i] <= '0;
            end
        end else if (i_step) begin
            r_last_time <= i_edge_time;
            r_index     <= n_index;
            r_width     <= n_width;
        end
    end

endmodule

// ===== hw/rtl/ppm_rc_channel_decoder_core.sv =====
// Top level of the PPM radio-control channel decoder.
//
// The slave stream takes one item per rising edge of the PPM pulse train: tdata holds
// the 32-bit timer value captured at that edge. The master stream gives one item for
// every input item, carrying the armed flag and the roll, pitch, throttle and yaw
// setpoints; tuser flags an edge that was a sync gap and restarted the frame.
// Registers are written through the plain write port while no item is in flight;
// the user must keep to this, as the block itself does not enforce it.
// Each item passes an input register, the frame tracker stage that updates the
// channel store, and the setpoint stage, each of them registered. One item is
// accepted every cycle while the receiver takes results; the 32-bit interval
// subtract and compare in the frame tracker sets the clock period.
//
// Synchronous reset empties the pipeline, restores the register defaults, zeroes
// the last edge time and the channel index and clears the channel store at once.
// When the receiver stalls, the stages fill up in turn and tready falls only once
// all three hold an item; nothing is dropped.
module ppm_rc_channel_decoder_core #(
    parameter int NUM_CHANNELS = ppmrc_pkg::NUM_CHANNELS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [31:0] edge_time
    input  logic [ppmrc_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [0] armed, [13:1] roll_set, [26:14] pitch_set, [39:27] throttle_set,
    // [52:40] yaw_set, [55:53] zero
    output logic [ppmrc_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    // [0] frame_sync
    output logic                                o_m_axis_tuser,
    input  logic                                i_cfg_we,
    input  logic [ppmrc_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [ppmrc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    localparam int SW = ppmrc_pkg::SET_W;

    ppmrc_pkg::t_cfg  r_cfg;
    ppmrc_pkg::t_snap r_snap;
    ppmrc_pkg::t_snap frame_snap;

    logic                              r_in_valid;
    logic [ppmrc_pkg::TIME_W-1:0]      r_in_time;
    logic                              r_snap_valid;
    logic                              r_out_valid;
    logic [ppmrc_pkg::M_TDATA_W-1:0]   r_out_data;
    logic                              r_out_sync;

    logic                              in_acc;
    logic                              adv1;
    logic                              adv2;
    logic signed [SW-1:0]              roll;
    logic signed [SW-1:0]              pitch;
    logic signed [SW-1:0]              throttle;
    logic signed [SW-1:0]              yaw;
    logic [SW-1:0]                     yaw_mag;
    logic signed [SW-1:0]              yaw_set;
    logic                              armed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_gap      <= ppmrc_pkg::RST_SYNC_GAP;
            r_cfg.min_width     <= ppmrc_pkg::RST_MIN_WIDTH;
            r_cfg.max_width     <= ppmrc_pkg::RST_MAX_WIDTH;
            r_cfg.arm_threshold <= ppmrc_pkg::RST_ARM_THRESHOLD;
            r_cfg.yaw_deadband  <= ppmrc_pkg::RST_YAW_DEADBAND;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ppmrc_pkg::CFG_SYNC_GAP: begin
                    r_cfg.sync_gap <= i_cfg_wdata;
                end
                ppmrc_pkg::CFG_MIN_WIDTH: begin
                    r_cfg.min_width <= i_cfg_wdata[ppmrc_pkg::WIDTH_W-1:0];
                end
                ppmrc_pkg::CFG_MAX_WIDTH: begin
                    r_cfg.max_width <= i_cfg_wdata[ppmrc_pkg::WIDTH_W-1:0];
                end
                ppmrc_pkg::CFG_ARM_THRESHOLD: begin
                    r_cfg.arm_threshold <= i_cfg_wdata[ppmrc_pkg::WIDTH_W-1:0];
                end
                ppmrc_pkg::CFG_YAW_DEADBAND: begin
                    r_cfg.yaw_deadband <= i_cfg_wdata[ppmrc_pkg::DEADBAND_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign adv2            = r_snap_valid && (!r_out_valid || i_m_axis_tready);
    assign adv1            = r_in_valid && (!r_snap_valid || adv2);
    assign o_s_axis_tready = !r_in_valid || adv1;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    ppmrc_frame #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (adv1),
        .i_edge_time (r_in_time),
        .i_cfg       (r_cfg),
        .o_snap      (frame_snap)
    );

    always_comb begin
        roll     = $signed({1'b0, r_snap.roll_w}) - ppmrc_pkg::MID_WIDTH;
        pitch    = $signed({1'b0, r_snap.pitch_w}) - ppmrc_pkg::MID_WIDTH;
        throttle = $signed({1'b0, r_snap.throttle_w}) - ppmrc_pkg::LOW_WIDTH;
        yaw      = $signed({1'b0, r_snap.yaw_w}) - ppmrc_pkg::MID_WIDTH;
        yaw_mag  = yaw[SW-1] ? SW'(-yaw) : SW'(yaw);
        yaw_set  = (yaw_mag < SW'(r_cfg.yaw_deadband)) ? '0 : yaw;
        armed    = r_snap.arm_w > r_cfg.arm_threshold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_snap_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (adv1) begin
                r_in_valid <= 1'b0;
            end
            if (adv1) begin
                r_snap_valid <= 1'b1;
            end else if (adv2) begin
                r_snap_valid <= 1'b0;
            end
            if (adv2) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_time <= i_s_axis_tdata;
        end
        if (adv1) begin
            r_snap <= frame_snap;
        end
        if (adv2) begin
            r_out_data <= {3'b000, yaw_set, throttle, pitch, roll, armed};
            r_out_sync <= r_snap.sync;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_sync;

    a_snap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_snap_valid && !adv2) |=> (r_snap_valid && $stable(r_snap)))
        else $error("Waiting frame snapshot changed or was lost.");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_snap_valid && r_out_valid && !i_m_axis_tready)
        |-> !o_s_axis_tready)
        else $error("Input accepted while every stage is full and stalled.");

    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> (!o_m_axis_tvalid && !r_snap_valid && !r_in_valid))
        else $error("Pipeline not empty after reset.");

endmodule

// ===== verif/ppm_rc_channel_decoder_core_test.sv =====
// Self-checking testbench of the PPM radio-control channel decoder core and its predictor.
module ppm_rc_channel_decoder_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               armed;
        logic signed [12:0] roll;
        logic signed [12:0] pitch;
        logic signed [12:0] throttle;
        logic signed [12:0] yaw;
        logic               sync;
    } t_rc_setpoints;

    typedef struct packed {
        bit            absolute;
        logic [31:0]   value;
        bit            typed;
        t_rc_setpoints setpoints;
    } t_edge_row;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          HOLD_CYCLES = 300;

    localparam t_rc_setpoints UNSET = '0;
    localparam t_rc_setpoints EMPTY_STORE =
        '{1'b0, -13'sd1500, -13'sd1500, -13'sd1000, -13'sd1500, 1'b0};
    localparam t_rc_setpoints EMPTY_STORE_SYNC =
        '{1'b0, -13'sd1500, -13'sd1500, -13'sd1000, -13'sd1500, 1'b1};

    localparam ppmrc_pkg::t_cfg RESET_CFG = '{ppmrc_pkg::RST_SYNC_GAP,
                                              ppmrc_pkg::RST_MIN_WIDTH,
                                              ppmrc_pkg::RST_MAX_WIDTH,
                                              ppmrc_pkg::RST_ARM_THRESHOLD,
                                              ppmrc_pkg::RST_YAW_DEADBAND};
    localparam ppmrc_pkg::t_cfg WIDE_CFG  = '{16'hFFFF, 12'd0, 12'hFFF, 12'hFFF, 10'h3FF};
    localparam ppmrc_pkg::t_cfg SHUT_CFG  = '{16'd0, 12'hFFF, 12'd0, 12'd0, 10'd0};

    localparam t_edge_row EDGE_TABLE [0:21] = '{
        '{1'b1, 32'd0,          1'b1, EMPTY_STORE},
        '{1'b1, 32'd5000,       1'b1, EMPTY_STORE_SYNC},
        '{1'b0, 32'd1500,       1'b0, UNSET},
        '{1'b0, 32'd801,        1'b0, UNSET},
        '{1'b0, 32'd2199,       1'b0, UNSET},
        '{1'b0, 32'd1515,       1'b0, UNSET},
        '{1'b0, 32'd1751,       1'b0, UNSET},
        '{1'b0, 32'd800,        1'b0, UNSET},
        '{1'b0, 32'd2200,       1'b0, UNSET},
        '{1'b0, 32'd1000,       1'b0, UNSET},
        '{1'b0, 32'd1000,       1'b0, UNSET},
        '{1'b0, 32'd3000,       1'b0, UNSET},
        '{1'b0, 32'd3001,       1'b0, UNSET},
        '{1'b0, 32'd1200,       1'b0, UNSET},
        '{1'b0, 32'd1200,       1'b0, UNSET},
        '{1'b0, 32'd1000,       1'b0, UNSET},
        '{1'b0, 32'd1486,       1'b0, UNSET},
        '{1'b0, 32'd1750,       1'b0, UNSET},
        '{1'b1, 32'hFFFFFFFF,   1'b0, UNSET},
        '{1'b0, 32'd1500,       1'b0, UNSET},
        '{1'b1, 32'hAAAAAAAA,   1'b0, UNSET},
        '{1'b1, 32'h55555555,   1'b0, UNSET}
    };

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [ppmrc_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [ppmrc_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                             m_tuser;
    logic                             cfg_we = 1'b0;
    logic [ppmrc_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [ppmrc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    ppmrc_pkg::t_cfg               cfg_model;
    logic [31:0]                   last_edge;
    int                            chan_index;
    logic [ppmrc_pkg::WIDTH_W-1:0] chan_width [ppmrc_pkg::NUM_CHANNELS];

    t_rc_setpoints expected_setpoints [$];
    logic [31:0]   sent_time;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            hold_requests;
    int            holds_served;
    int            hold_left;
    int            mismatch_count;
    int unsigned   cycle_count;

    ppm_rc_channel_decoder_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic t_rc_setpoints predict_setpoints(input logic [31:0] now);
        t_rc_setpoints sp;
        logic [31:0]   dt;
        int            yaw_off;
        int            yaw_mag;
        dt = now - last_edge;
        last_edge = now;
        sp.sync = 1'b0;
        if (dt > 32'(cfg_model.sync_gap)) begin
            chan_index = 0;
            sp.sync = 1'b1;
        end else if (chan_index < ppmrc_pkg::NUM_CHANNELS) begin
            if (dt > 32'(cfg_model.min_width) && dt < 32'(cfg_model.max_width)) begin
                chan_width[chan_index] = dt[ppmrc_pkg::WIDTH_W-1:0];
            end
            chan_index++;
        end
        sp.armed    = chan_width[ppmrc_pkg::CH_ARM] > cfg_model.arm_threshold;
        sp.roll     = 13'(int'(chan_width[ppmrc_pkg::CH_ROLL]) - int'(ppmrc_pkg::MID_WIDTH));
        sp.pitch    = 13'(int'(chan_width[ppmrc_pkg::CH_PITCH]) - int'(ppmrc_pkg::MID_WIDTH));
        sp.throttle = 13'(int'(chan_width[ppmrc_pkg::CH_THROTTLE])
                          - int'(ppmrc_pkg::LOW_WIDTH));
        yaw_off     = int'(chan_width[ppmrc_pkg::CH_YAW]) - int'(ppmrc_pkg::MID_WIDTH);
        yaw_mag     = (yaw_off < 0) ? -yaw_off : yaw_off;
        if (yaw_mag < int'(cfg_model.yaw_deadband)) begin
            yaw_off = 0;
        end
        sp.yaw = 13'(yaw_off);
        return sp;
    endfunction

    task automatic send_edge(input logic [31:0] t, input bit typed, input t_rc_setpoints sp);
        t_rc_setpoints predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= t;
        do @(posedge clk); while (!s_tready);
        sent_time = t;
        predicted = predict_setpoints(t);
        expected_setpoints.push_back(typed ? sp : predicted);
    endtask

    task automatic send_delta(input logic [31:0] delta);
        send_edge(sent_time + delta, 1'b0, UNSET);
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_setpoints.size() != 0) @(posedge clk);
    endtask

    task automatic write_config(input ppmrc_pkg::t_cfg c);
        logic [ppmrc_pkg::CFG_DATA_W-1:0] vals [5];
        logic [ppmrc_pkg::CFG_ADDR_W-1:0] idx  [5];
        vals = '{ppmrc_pkg::CFG_DATA_W'(c.sync_gap), ppmrc_pkg::CFG_DATA_W'(c.min_width),
                 ppmrc_pkg::CFG_DATA_W'(c.max_width), ppmrc_pkg::CFG_DATA_W'(c.arm_threshold),
                 ppmrc_pkg::CFG_DATA_W'(c.yaw_deadband)};
        idx  = '{ppmrc_pkg::CFG_SYNC_GAP, ppmrc_pkg::CFG_MIN_WIDTH, ppmrc_pkg::CFG_MAX_WIDTH,
                 ppmrc_pkg::CFG_ARM_THRESHOLD, ppmrc_pkg::CFG_YAW_DEADBAND};
        for (int r = 0; r < 5; r++) begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_addr  <= idx[r];
            cfg_wdata <= vals[r];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_model = c;
    endtask

    function automatic ppmrc_pkg::t_cfg random_config();
        ppmrc_pkg::t_cfg c;
        c.sync_gap      = 16'($urandom_range(2300, 65535));
        c.min_width     = 12'($urandom_range(0, 1500));
        c.max_width     = 12'($urandom_range(1600, 4095));
        c.arm_threshold = 12'($urandom_range(0, 4095));
        c.yaw_deadband  = 10'($urandom_range(0, 1023));
        return c;
    endfunction

    task automatic run_random(input int n_items);
        int          sent;
        int          kind;
        int          n_ch;
        int          lo;
        int          hi;
        logic [31:0] delta;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                send_delta(32'(cfg_model.sync_gap) + $urandom_range(1, 6000));
                sent++;
                n_ch = ($urandom_range(0, 9) < 2) ? $urandom_range(1, 11)
                                                  : ppmrc_pkg::NUM_CHANNELS;
                lo = int'(cfg_model.min_width) + 1;
                hi = int'(cfg_model.max_width) - 1;
                for (int c = 0; c < n_ch; c++) begin
                    if (hi >= lo && $urandom_range(0, 9) < 8) begin
                        send_delta($urandom_range(lo, hi));
                    end else begin
                        send_delta($urandom_range(0, 4095));
                    end
                    sent++;
                end
            end else if (kind < 90) begin
                send_edge($urandom, 1'b0, UNSET);
                sent++;
            end else begin
                case ($urandom_range(0, 5))
                    0: delta = 32'(cfg_model.sync_gap);
                    1: delta = 32'(cfg_model.sync_gap) + 1;
                    2: delta = 32'd0;
                    3: delta = 32'(cfg_model.min_width);
                    4: delta = 32'(cfg_model.max_width);
                    default: delta = $urandom_range(0, 5000);
                endcase
                send_delta(delta);
                sent++;
            end
        end
    endtask

    always @(negedge clk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (holds_served != hold_requests) begin
            holds_served = holds_served + 1;
            hold_left    = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        t_rc_setpoints got;
        t_rc_setpoints want;
        if (rst_n && m_tvalid && m_tready) begin
            got.armed    = m_tdata[0];
            got.roll     = m_tdata[13:1];
            got.pitch    = m_tdata[26:14];
            got.throttle = m_tdata[39:27];
            got.yaw      = m_tdata[52:40];
            got.sync     = m_tuser;
            if (expected_setpoints.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display({"unexpected item: armed=%0d roll=%0d pitch=%0d thr=%0d",
                              " yaw=%0d sync=%0d"},
                             got.armed, got.roll, got.pitch, got.throttle, got.yaw, got.sync);
                end
            end else begin
                want = expected_setpoints.pop_front();
                if (got.armed !== want.armed || got.roll !== want.roll ||
                    got.pitch !== want.pitch || got.throttle !== want.throttle ||
                    got.yaw !== want.yaw || got.sync !== want.sync) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display({"mismatch expected: armed=%0d roll=%0d pitch=%0d thr=%0d",
                                  " yaw=%0d sync=%0d"},
                                 want.armed, want.roll, want.pitch, want.throttle, want.yaw,
                                 want.sync);
                        $display({"         actual:   armed=%0d roll=%0d pitch=%0d thr=%0d",
                                  " yaw=%0d sync=%0d"},
                                 got.armed, got.roll, got.pitch, got.throttle, got.yaw,
                                 got.sync);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ppm_rc_channel_decoder_core_test failed");
            $finish;
        end
    end

    initial begin
        cfg_model      = RESET_CFG;
        last_edge      = '0;
        chan_index     = 0;
        for (int c = 0; c < ppmrc_pkg::NUM_CHANNELS; c++) begin
            chan_width[c] = '0;
        end
        sent_time      = '0;
        send_idle_pct  = 25;
        recv_idle_pct  = 61;
        hold_requests  = 0;
        holds_served   = 0;
        hold_left      = 0;
        mismatch_count = 0;
        cycle_count    = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (EDGE_TABLE[r]) begin
            if (EDGE_TABLE[r].absolute) begin
                send_edge(EDGE_TABLE[r].value, EDGE_TABLE[r].typed, EDGE_TABLE[r].setpoints);
            end else begin
                send_edge(sent_time + EDGE_TABLE[r].value, EDGE_TABLE[r].typed,
                          EDGE_TABLE[r].setpoints);
            end
        end
        drain_results();

        write_config(WIDE_CFG);
        run_random(150);
        drain_results();

        send_idle_pct = 61;
        recv_idle_pct = 25;
        write_config(SHUT_CFG);
        run_random(80);
        drain_results();

        write_config(random_config());
        run_random(150);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_config(RESET_CFG);
        run_random(60);
        hold_requests++;
        run_random(60);
        drain_results();
        run_random(80);
        drain_results();

        write_config(random_config());
        run_random(150);
        drain_results();

        repeat (20) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("ppm_rc_channel_decoder_core_test passed");
        end else begin
            $display("ppm_rc_channel_decoder_core_test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ppmrc_pkg.sv
hw/rtl/ppmrc_frame.sv
hw/rtl/ppm_rc_channel_decoder_core.sv
verif/ppm_rc_channel_decoder_core_test.sv
